>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define KAR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// next-cycle implication, disabled while in reset
`define KAR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

>>> rtl/kar_pkg.sv
// ----------------------------------------------------------------------------
// kar_pkg
// shared constants for the key auto-repeat qualifier
// ----------------------------------------------------------------------------
package kar_pkg;

    localparam int NUM_KEYS_DEF   = 256;
    localparam int TIME_WIDTH_DEF = 32;

    localparam int KEY_W     = 8;
    localparam int TIME_IN_W = 32;
    localparam int CFG_W     = 16;
    localparam int PDATA_W   = 32;
    localparam int PADDR_W   = 3;

    localparam logic [CFG_W-1:0] INIT_DELAY_RST      = 16'h0200;
    localparam logic [CFG_W-1:0] REPEAT_INTERVAL_RST = 16'h0050;

    // register select, taken from paddr bit 2
    localparam logic REG_INITIAL_DELAY   = 1'b0;
    localparam logic REG_REPEAT_INTERVAL = 1'b1;

endpackage

>>> rtl/kar_ifs.sv
// ----------------------------------------------------------------------------
// kar_ifs
// valid/ready channel interfaces for key samples and results
// ----------------------------------------------------------------------------
interface kar_sample_if;
    logic                          valid;
    logic                          ready;
    logic [kar_pkg::KEY_W-1:0]     key_index;
    logic                          pressed;
    logic                          repeat_mode;
    logic [kar_pkg::TIME_IN_W-1:0] now_time;

    modport source (output valid, key_index, pressed, repeat_mode, now_time, input ready);
    modport sink   (input valid, key_index, pressed, repeat_mode, now_time, output ready);
endinterface

interface kar_result_if;
    logic                      valid;
    logic                      ready;
    logic                      fire;
    logic [kar_pkg::KEY_W-1:0] key_echo;

    modport source (output valid, fire, key_echo, input ready);
    modport sink   (input valid, fire, key_echo, output ready);
endinterface

>>> rtl/key_autorepeat_qualifier_top.sv
// ----------------------------------------------------------------------------
// key_autorepeat_qualifier_top
// per-key typematic repeat qualifier over a single key-state memory
// ----------------------------------------------------------------------------
// channel   dir   handshake       payload
// sample    in    valid/ready     key_index, pressed, repeat_mode, now_time
// result    out   valid/ready     fire, key_echo
// apb       in    psel/penable    initial_delay @0x0, repeat_interval @0x4
//
// one beat per cycle sustained unless result stalls; a beat reads its key entry at
// acceptance, writes it back as the entry stage advances, a back-to-back hit on
// the same key is forwarded; the result is registered as the entry stage advances
// after reset the key memory is cleared entry by entry, with sample.ready low
// a stalled result holds the entry stage, which holds sample.ready low
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module key_autorepeat_qualifier_top #(
    parameter int NUM_KEYS   = kar_pkg::NUM_KEYS_DEF,
    parameter int TIME_WIDTH = kar_pkg::TIME_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [kar_pkg::PADDR_W-1:0] paddr,
    input  logic [kar_pkg::PDATA_W-1:0] pwdata,
    output logic [kar_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    kar_sample_if.sink                  sample,
    kar_result_if.source                result
);

    localparam int KEY_AW  = $clog2(NUM_KEYS);
    localparam int KEY_NW  = $clog2(NUM_KEYS + 1);
    localparam int KEY_CW  = (KEY_NW > kar_pkg::KEY_W) ? KEY_NW : kar_pkg::KEY_W;
    localparam int CMP_W   = (TIME_WIDTH > kar_pkg::CFG_W) ? TIME_WIDTH : kar_pkg::CFG_W;
    localparam int TIME_XW = (TIME_WIDTH > kar_pkg::TIME_IN_W) ? TIME_WIDTH : kar_pkg::TIME_IN_W;
    localparam int ENT_W   = TIME_WIDTH + 2;
    localparam int DOWN_B  = ENT_W - 1;
    localparam int HELD_B  = ENT_W - 2;

    // configuration registers
    logic [kar_pkg::CFG_W-1:0] init_delay_reg;
    logic [kar_pkg::CFG_W-1:0] rpt_interval_reg;
    logic                      cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_delay_reg   <= kar_pkg::INIT_DELAY_RST;
            rpt_interval_reg <= kar_pkg::REPEAT_INTERVAL_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == kar_pkg::REG_INITIAL_DELAY)
                init_delay_reg <= pwdata[kar_pkg::CFG_W-1:0];
            else
                rpt_interval_reg <= pwdata[kar_pkg::CFG_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        case (paddr[2])
            kar_pkg::REG_INITIAL_DELAY:   prdata[kar_pkg::CFG_W-1:0] = init_delay_reg;
            kar_pkg::REG_REPEAT_INTERVAL: prdata[kar_pkg::CFG_W-1:0] = rpt_interval_reg;
            default:                      prdata = '0;
        endcase
    end

    // control and payload registers
    logic                          clr_busy_reg, clr_busy_next;
    logic [KEY_AW-1:0]             clr_cnt_reg, clr_cnt_next;
    logic                          s1_valid_reg, s1_valid_next;
    logic [kar_pkg::KEY_W-1:0]     s1_key_reg;
    logic                          s1_pressed_reg;
    logic                          s1_rmode_reg;
    logic [TIME_WIDTH-1:0]         s1_now_reg;
    logic                          out_valid_reg, out_valid_next;
    logic                          out_fire_reg;
    logic [kar_pkg::KEY_W-1:0]     out_key_reg;
    logic                          fwd_valid_reg, fwd_valid_next;
    logic [KEY_AW-1:0]             fwd_addr_reg;
    logic [ENT_W-1:0]              fwd_data_reg;
    logic [ENT_W-1:0]              rd_data_reg;

    // key-state memory
    logic [ENT_W-1:0]              mem [NUM_KEYS];

    logic                          accept;
    logic                          s1_adv;
    logic [KEY_CW-1:0]             in_key_ext;
    logic [KEY_CW-1:0]             s1_key_ext;
    logic [KEY_AW-1:0]             rd_addr;
    logic [KEY_AW-1:0]             s1_addr;
    logic                          s1_in_range;
    logic [TIME_XW-1:0]            now_ext;
    logic [ENT_W-1:0]              entry;
    logic                          e_down;
    logic                          e_held;
    logic [TIME_WIDTH-1:0]         e_last;
    logic [TIME_WIDTH-1:0]         elapsed;
    logic [kar_pkg::CFG_W-1:0]     limit;
    logic                          rep_fire;
    logic                          fire;
    logic [ENT_W-1:0]              new_entry;
    logic                          wr_en;
    logic [KEY_AW-1:0]             wr_addr;
    logic [ENT_W-1:0]              wr_data;

    assign s1_adv       = s1_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !clr_busy_reg && (!s1_valid_reg || s1_adv);
    assign accept       = sample.valid && sample.ready;

    assign in_key_ext = KEY_CW'(sample.key_index);
    assign rd_addr    = in_key_ext[KEY_AW-1:0];
    assign now_ext    = TIME_XW'(sample.now_time);

    assign s1_key_ext  = KEY_CW'(s1_key_reg);
    assign s1_addr     = s1_key_ext[KEY_AW-1:0];
    assign s1_in_range = s1_key_ext < KEY_CW'(NUM_KEYS);

    // entry update
    always_comb
    begin
        entry    = (fwd_valid_reg && fwd_addr_reg == s1_addr) ? fwd_data_reg : rd_data_reg;
        e_down   = entry[DOWN_B];
        e_held   = entry[HELD_B];
        e_last   = entry[TIME_WIDTH-1:0];
        elapsed  = s1_now_reg - e_last;
        limit    = e_held ? rpt_interval_reg : init_delay_reg;
        rep_fire = !e_down || (CMP_W'(elapsed) > CMP_W'(limit));
        fire     = s1_in_range && s1_pressed_reg && (!s1_rmode_reg || rep_fire);

        new_entry                   = entry;
        new_entry[DOWN_B]           = s1_pressed_reg;
        new_entry[HELD_B]           = s1_pressed_reg
                                      && (e_held || (s1_rmode_reg && rep_fire && e_down));
        if (s1_pressed_reg && s1_rmode_reg && rep_fire)
            new_entry[TIME_WIDTH-1:0] = s1_now_reg;
    end

    assign wr_en   = clr_busy_reg || (s1_adv && s1_in_range);
    assign wr_addr = clr_busy_reg ? clr_cnt_reg : s1_addr;
    assign wr_data = clr_busy_reg ? '0 : new_entry;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (accept)
            rd_data_reg <= mem[rd_addr];
    end

    // next-state logic
    always_comb
    begin
        clr_busy_next  = clr_busy_reg;
        clr_cnt_next   = clr_cnt_reg;
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        fwd_valid_next = fwd_valid_reg;

        if (clr_busy_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == KEY_AW'(NUM_KEYS - 1))
                clr_busy_next = 1'b0;
        end

        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;

        if (s1_adv)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;

        if (wr_en && !clr_busy_reg)
            fwd_valid_next = 1'b1;
        else if (accept)
            fwd_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            clr_busy_reg  <= clr_busy_next;
            clr_cnt_reg   <= clr_cnt_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            fwd_valid_reg <= fwd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_key_reg     <= sample.key_index;
            s1_pressed_reg <= sample.pressed;
            s1_rmode_reg   <= sample.repeat_mode;
            s1_now_reg     <= now_ext[TIME_WIDTH-1:0];
        end
        if (s1_adv)
        begin
            out_fire_reg <= fire;
            out_key_reg  <= s1_key_reg;
        end
        if (wr_en && !clr_busy_reg)
        begin
            fwd_addr_reg <= wr_addr;
            fwd_data_reg <= wr_data;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.fire     = out_fire_reg;
    assign result.key_echo = out_key_reg;

    `KAR_ASSERT_IMP(a_clear_idle, clk, rst_n, clr_busy_reg, !s1_valid_reg && !out_valid_reg)
    `KAR_ASSERT_NXT(a_stall_holds, clk, rst_n, s1_valid_reg && !s1_adv,
        s1_valid_reg && $stable(s1_key_reg) && $stable(s1_now_reg))
    `KAR_ASSERT_NXT(a_fwd_capture, clk, rst_n, wr_en && !clr_busy_reg,
        fwd_valid_reg && fwd_addr_reg == $past(wr_addr))

endmodule
